/* src/rc4_stream_cipher_unit_defines.svh */
// assertion macros used by the rc4 engine datapath
`ifndef RC4_STREAM_CIPHER_UNIT_DEFINES_SVH
`define RC4_STREAM_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication, clocked by clk, off during reset
`define RC4_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked by clk, off during reset
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rc4_pkg.sv */
// rc4 engine package: sizes, codes, control word types and the microcode rom
package rc4_pkg;

	localparam int BYTE_W        = 8;
	localparam int PERM_DEPTH    = 256;
	localparam int PERM_AW       = $clog2(PERM_DEPTH);
	localparam int MAX_KEY_BYTES = 256;
	localparam int KEY_CNT_W     = $clog2(MAX_KEY_BYTES + 1);
	localparam int NUM_STEPS     = 10;
	localparam int STEP_W        = $clog2(NUM_STEPS);

	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [PERM_AW-1:0]   perm_addr_t;
	typedef logic [KEY_CNT_W-1:0] key_cnt_t;
	typedef logic [STEP_W-1:0]    step_t;

	// item opcodes
	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_DATA = 1'b1;

	// datapath micro-operations
	typedef enum logic [3:0] {
		UOP_IDLE,
		UOP_D1,
		UOP_D2,
		UOP_D3,
		UOP_KINIT,
		UOP_K0,
		UOP_K1,
		UOP_K2,
		UOP_K3,
		UOP_KFIN
	} uop_t;

	// sequencer branch conditions
	typedef enum logic [2:0] {
		COND_NEXT,
		COND_JUMP,
		COND_DISPATCH,
		COND_WAIT_OUT,
		COND_LOOP
	} cond_t;

	localparam step_t STEP_IDLE  = step_t'(0);
	localparam step_t STEP_D1    = step_t'(1);
	localparam step_t STEP_D2    = step_t'(2);
	localparam step_t STEP_D3    = step_t'(3);
	localparam step_t STEP_KINIT = step_t'(4);
	localparam step_t STEP_K0    = step_t'(5);
	localparam step_t STEP_K1    = step_t'(6);
	localparam step_t STEP_K2    = step_t'(7);
	localparam step_t STEP_K3    = step_t'(8);
	localparam step_t STEP_KFIN  = step_t'(9);

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		step_t target;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		uop_t uop;
		logic go;
	} rc4_ctl_t;

	// datapath to sequencer
	typedef struct packed {
		logic in_valid;
		logic is_data;
		logic key_last;
		logic out_free;
		logic loop_done;
	} rc4_status_t;

	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		unique case (s)
			STEP_IDLE:  w = '{UOP_IDLE,  COND_DISPATCH, STEP_KINIT};
			STEP_D1:    w = '{UOP_D1,    COND_NEXT,     STEP_IDLE};
			STEP_D2:    w = '{UOP_D2,    COND_NEXT,     STEP_IDLE};
			STEP_D3:    w = '{UOP_D3,    COND_WAIT_OUT, STEP_IDLE};
			STEP_KINIT: w = '{UOP_KINIT, COND_NEXT,     STEP_IDLE};
			STEP_K0:    w = '{UOP_K0,    COND_NEXT,     STEP_IDLE};
			STEP_K1:    w = '{UOP_K1,    COND_NEXT,     STEP_IDLE};
			STEP_K2:    w = '{UOP_K2,    COND_NEXT,     STEP_IDLE};
			STEP_K3:    w = '{UOP_K3,    COND_LOOP,     STEP_K0};
			STEP_KFIN:  w = '{UOP_KFIN,  COND_JUMP,     STEP_IDLE};
			default:    w = '{UOP_IDLE,  COND_JUMP,     STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

/* src/rc4_in_if.sv */
// input channel: key or data byte with valid/ready
interface rc4_in_if;
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [rc4_pkg::BYTE_W-1:0] value;
	logic                 key_last;

	modport source (output valid, output op, output value, output key_last, input ready);
	modport sink (input valid, input op, input value, input key_last, output ready);
endinterface

/* src/rc4_out_if.sv */
// output channel: result byte with valid/ready
interface rc4_out_if;
	logic                 valid;
	logic                 ready;
	logic [rc4_pkg::BYTE_W-1:0] result_byte;

	modport source (output valid, output result_byte, input ready);
	modport sink (input valid, input result_byte, output ready);
endinterface

/* src/rc4_stream_cipher_unit.sv */
// RC4 stream cipher engine, one byte per transfer: key bytes (op 0) are stored, and
// the key byte flagged key_last starts the key schedule; data bytes (op 1) return
// the byte XOR the next keystream byte. A data byte runs through a chain of
// dependent registered reads of the permutation RAM (one read and one write
// port): read S[i], read S[j], write S[i] with the keystream read, write S[j]
// and load the result; no new byte is accepted until these steps are done. The
// last of these steps waits while the previous result is still unread. The last
// key byte is followed by a schedule (a swap per entry over 256 entries plus
// setup and wrap-up) during which no transfer is accepted. The permutation needs
// no clearing pass after reset: per-entry valid flags make untouched entries read
// as the identity. A finished result waits in an output register, so the next
// byte can be taken while it is pending.
module rc4_stream_cipher_unit (
	input logic         clk,
	input logic         arst_n,
	rc4_in_if.sink      item,
	rc4_out_if.source   result
);

	rc4_pkg::rc4_ctl_t    ctl;
	rc4_pkg::rc4_status_t status;

	rc4_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.status(status),
		.ctl   (ctl)
	);

	rc4_datapath u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.status(status),
		.item  (item),
		.result(result)
	);

endmodule

/* src/rc4_ram.sv */
// generic single-write, single-read ram with registered read data
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/rc4_seq.sv */
// microcode sequencer: step counter, control rom lookup and branch logic
module rc4_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rc4_pkg::rc4_status_t status,
	output rc4_pkg::rc4_ctl_t    ctl
);

	rc4_pkg::step_t  step_q;
	rc4_pkg::step_t  step_nxt;
	rc4_pkg::step_t  step_inc;
	rc4_pkg::ucode_t uw;
	logic            go;

	assign uw       = rc4_pkg::ucode_rom(step_q);
	assign step_inc = step_q + rc4_pkg::step_t'(1);

	always_comb begin
		step_nxt = step_q;
		go       = 1'b1;
		unique case (uw.cond)
			rc4_pkg::COND_NEXT: begin
				step_nxt = step_inc;
			end
			rc4_pkg::COND_JUMP: begin
				step_nxt = uw.target;
			end
			rc4_pkg::COND_DISPATCH: begin
				go = status.in_valid;
				if (status.in_valid) begin
					if (status.is_data) begin
						step_nxt = step_inc;
					end else if (status.key_last) begin
						step_nxt = uw.target;
					end
				end
			end
			rc4_pkg::COND_WAIT_OUT: begin
				go = status.out_free;
				if (status.out_free) begin
					step_nxt = uw.target;
				end
			end
			rc4_pkg::COND_LOOP: begin
				step_nxt = status.loop_done ? step_inc : uw.target;
			end
			default: begin
				step_nxt = rc4_pkg::STEP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= rc4_pkg::STEP_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

	assign ctl.uop = uw.uop;
	assign ctl.go  = go;

endmodule

/* src/rc4_datapath.sv */
// rc4 datapath: permutation and key rams, indices, swap forwarding, result register
`include "rc4_stream_cipher_unit_defines.svh"

module rc4_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rc4_pkg::rc4_ctl_t    ctl,
	output rc4_pkg::rc4_status_t status,
	rc4_in_if.sink               item,
	rc4_out_if.source            result
);

	rc4_pkg::perm_addr_t i_q;
	rc4_pkg::perm_addr_t j_q;
	rc4_pkg::perm_addr_t n_q;
	rc4_pkg::perm_addr_t kpos_q;
	rc4_pkg::key_cnt_t   key_count_q;
	rc4_pkg::key_cnt_t   kpos_inc;
	logic [rc4_pkg::PERM_DEPTH-1:0] valid_q;
	logic                out_valid_q;
	rc4_pkg::byte_t      out_byte_q;
	rc4_pkg::byte_t      val_q;
	rc4_pkg::byte_t      si_q;
	rc4_pkg::byte_t      sj_q;
	rc4_pkg::perm_addr_t t_q;
	logic                pvld_q;
	rc4_pkg::perm_addr_t praddr_q;

	rc4_pkg::perm_addr_t p_raddr;
	rc4_pkg::perm_addr_t p_waddr;
	rc4_pkg::byte_t      p_wdata;
	logic                p_we;
	rc4_pkg::byte_t      p_rdata;
	rc4_pkg::byte_t      pval;
	rc4_pkg::byte_t      k_rdata;
	logic                k_we;
	logic                accept;
	logic                out_free;
	logic                d3_fire;
	rc4_pkg::byte_t      ks;

	assign accept   = ctl.go && (ctl.uop == rc4_pkg::UOP_IDLE);
	assign out_free = !out_valid_q || result.ready;
	assign d3_fire  = ctl.go && (ctl.uop == rc4_pkg::UOP_D3);
	assign kpos_inc = rc4_pkg::key_cnt_t'(kpos_q) + rc4_pkg::key_cnt_t'(1);

	// entries never written since the last identity reset read as their own index
	assign pval = pvld_q ? p_rdata : praddr_q;

	// keystream index can hit a swapped entry whose write is still in flight
	always_comb begin
		if (t_q == j_q) begin
			ks = si_q;
		end else if (t_q == i_q) begin
			ks = sj_q;
		end else begin
			ks = pval;
		end
	end

	assign k_we = accept && (item.op == rc4_pkg::OP_KEY)
		&& (key_count_q < rc4_pkg::key_cnt_t'(rc4_pkg::MAX_KEY_BYTES));

	always_comb begin
		p_raddr = n_q;
		p_waddr = n_q;
		p_wdata = pval;
		p_we    = 1'b0;
		unique case (ctl.uop)
			rc4_pkg::UOP_IDLE:  p_raddr = i_q + rc4_pkg::perm_addr_t'(1);
			rc4_pkg::UOP_D1:    p_raddr = j_q + pval;
			rc4_pkg::UOP_D2: begin
				p_raddr = si_q + pval;
				p_waddr = i_q;
				p_wdata = pval;
				p_we    = 1'b1;
			end
			rc4_pkg::UOP_D3: begin
				p_raddr = t_q;
				p_waddr = j_q;
				p_wdata = si_q;
				p_we    = ctl.go;
			end
			rc4_pkg::UOP_KINIT: p_raddr = n_q;
			rc4_pkg::UOP_K0:    p_raddr = n_q;
			rc4_pkg::UOP_K1:    p_raddr = j_q + pval + k_rdata;
			rc4_pkg::UOP_K2: begin
				p_waddr = n_q;
				p_wdata = pval;
				p_we    = 1'b1;
			end
			rc4_pkg::UOP_K3: begin
				p_waddr = j_q;
				p_wdata = si_q;
				p_we    = 1'b1;
			end
			rc4_pkg::UOP_KFIN:  p_raddr = n_q;
			default:            p_we    = 1'b0;
		endcase
	end

	rc4_ram #(
		.WIDTH(rc4_pkg::BYTE_W),
		.DEPTH(rc4_pkg::PERM_DEPTH)
	) u_perm_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(p_waddr),
		.wdata(p_wdata),
		.raddr(p_raddr),
		.rdata(p_rdata)
	);

	rc4_ram #(
		.WIDTH(rc4_pkg::BYTE_W),
		.DEPTH(rc4_pkg::PERM_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (k_we),
		.waddr(key_count_q[rc4_pkg::PERM_AW-1:0]),
		.wdata(item.value),
		.raddr(kpos_q),
		.rdata(k_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			kpos_q      <= '0;
			key_count_q <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			pvld_q      <= 1'b0;
		end else begin
			pvld_q <= valid_q[p_raddr];
			if (p_we) begin
				valid_q[p_waddr] <= 1'b1;
			end
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.go) begin
				unique case (ctl.uop)
					rc4_pkg::UOP_IDLE: begin
						if (item.op == rc4_pkg::OP_DATA) begin
							i_q <= i_q + rc4_pkg::perm_addr_t'(1);
						end else if (k_we) begin
							key_count_q <= key_count_q + rc4_pkg::key_cnt_t'(1);
						end
					end
					rc4_pkg::UOP_D1: j_q <= j_q + pval;
					rc4_pkg::UOP_D2: begin
					end
					rc4_pkg::UOP_D3: out_valid_q <= 1'b1;
					rc4_pkg::UOP_KINIT: begin
						valid_q <= '0;
						j_q     <= '0;
						n_q     <= '0;
						kpos_q  <= '0;
					end
					rc4_pkg::UOP_K0: begin
					end
					rc4_pkg::UOP_K1: j_q <= j_q + pval + k_rdata;
					rc4_pkg::UOP_K2: begin
					end
					rc4_pkg::UOP_K3: begin
						n_q <= n_q + rc4_pkg::perm_addr_t'(1);
						// key repeats cyclically over the stored length
						if (kpos_inc >= key_count_q) begin
							kpos_q <= '0;
						end else begin
							kpos_q <= kpos_inc[rc4_pkg::PERM_AW-1:0];
						end
					end
					rc4_pkg::UOP_KFIN: begin
						i_q         <= '0;
						j_q         <= '0;
						key_count_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		praddr_q <= p_raddr;
		if (accept) begin
			val_q <= item.value;
		end
		if (ctl.uop == rc4_pkg::UOP_D1 || ctl.uop == rc4_pkg::UOP_K1) begin
			si_q <= pval;
		end
		// S[j] is what lands in S[i] at the end of this step
		if (ctl.uop == rc4_pkg::UOP_D2) begin
			t_q  <= si_q + pval;
			sj_q <= pval;
		end
		if (d3_fire) begin
			out_byte_q <= val_q ^ ks;
		end
	end

	assign item.ready         = (ctl.uop == rc4_pkg::UOP_IDLE);
	assign result.valid       = out_valid_q;
	assign result.result_byte = out_byte_q;

	assign status.in_valid  = item.valid;
	assign status.is_data   = (item.op == rc4_pkg::OP_DATA);
	assign status.key_last  = item.key_last;
	assign status.out_free  = out_free;
	assign status.loop_done = (n_q == rc4_pkg::perm_addr_t'(rc4_pkg::PERM_DEPTH - 1));

	`RC4_ASSERT_NOW(a_key_count_max, 1'b1, key_count_q <= rc4_pkg::key_cnt_t'(rc4_pkg::MAX_KEY_BYTES), "key count above limit")
	`RC4_ASSERT_NOW(a_no_perm_write_idle, ctl.uop == rc4_pkg::UOP_IDLE, !p_we, "permutation write while idle")
	`RC4_ASSERT_NEXT(a_result_loaded, d3_fire, out_valid_q, "result not loaded after final data step")
	`RC4_ASSERT_NEXT(a_sched_clears, ctl.uop == rc4_pkg::UOP_KFIN, key_count_q == '0 && i_q == '0 && j_q == '0, "schedule end left state")

endmodule

/* verif/rc4_stream_cipher_unit_test.sv */
// self-checking testbench for the rc4 stream cipher unit
`timescale 1ns / 100ps

module rc4_stream_cipher_unit_test;

	localparam int ITEMS_PER_PHASE = 570;
	localparam int HOLD_LEN        = 300;
	localparam int WATCHDOG_LIMIT  = 8000;
	localparam int DRAIN_CYCLES    = 1100;

	typedef struct packed {
		logic           op;
		rc4_pkg::byte_t value;
		logic           key_last;
	} cipher_item_t;

	logic clk;
	logic arst_n;

	rc4_in_if  item_ch ();
	rc4_out_if res_ch ();

	rc4_stream_cipher_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch)
	);

	// cipher state mirrored by the testbench
	rc4_pkg::byte_t perm_s [rc4_pkg::PERM_DEPTH];
	rc4_pkg::byte_t key_bytes [rc4_pkg::MAX_KEY_BYTES];
	int unsigned    key_len;
	rc4_pkg::byte_t idx_i;
	rc4_pkg::byte_t idx_j;

	cipher_item_t   pending_items [$];
	rc4_pkg::byte_t expected_bytes [$];

	int unsigned send_idle_pct = 35;
	int unsigned recv_idle_pct = 74;
	int unsigned hold_trigger  = 0;
	int unsigned hold_served   = 0;
	int unsigned hold_left     = 0;
	int unsigned queued_total  = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles  = 0;
	logic        in_fire       = 1'b0;

	function automatic void run_key_schedule();
		rc4_pkg::byte_t jj;
		rc4_pkg::byte_t t;
		int unsigned    kp;
		jj = '0;
		kp = 0;
		for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++)
			perm_s[n] = rc4_pkg::byte_t'(n);
		for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
			jj = jj + perm_s[n] + key_bytes[kp];
			t = perm_s[n];
			perm_s[n] = perm_s[jj];
			perm_s[jj] = t;
			kp++;
			if (kp >= key_len)
				kp = 0;
		end
		idx_i = '0;
		idx_j = '0;
		key_len = 0;
	endfunction

	function automatic void rc4_advance(input cipher_item_t it);
		rc4_pkg::byte_t t;
		rc4_pkg::byte_t ks_addr;
		if (it.op == rc4_pkg::OP_KEY) begin
			// bytes past the key capacity are dropped
			if (key_len < rc4_pkg::MAX_KEY_BYTES) begin
				key_bytes[key_len] = it.value;
				key_len++;
			end
			if (it.key_last)
				run_key_schedule();
		end else begin
			idx_i = idx_i + 8'd1;
			idx_j = idx_j + perm_s[idx_i];
			t = perm_s[idx_i];
			perm_s[idx_i] = perm_s[idx_j];
			perm_s[idx_j] = t;
			ks_addr = perm_s[idx_i] + perm_s[idx_j];
			expected_bytes = {expected_bytes, it.value ^ perm_s[ks_addr]};
		end
	endfunction

	task automatic queue_item(input logic op, input rc4_pkg::byte_t value, input logic last);
		cipher_item_t it;
		it.op = op;
		it.value = value;
		it.key_last = last;
		pending_items = {pending_items, it};
		queued_total++;
	endtask

	task automatic queue_key(input int unsigned len);
		for (int k = 0; k < len; k++)
			queue_item(rc4_pkg::OP_KEY, rc4_pkg::byte_t'($urandom_range(0, 255)),
				k == len - 1);
	endtask

	task automatic queue_data(input int unsigned n);
		for (int k = 0; k < n; k++)
			queue_item(rc4_pkg::OP_DATA, rc4_pkg::byte_t'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
	endtask

	task automatic wait_sent();
		while (pending_items.size() != 0 || item_ch.valid)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.op = rc4_pkg::OP_KEY;
		item_ch.value = '0;
		item_ch.key_last = 1'b0;
		res_ch.ready = 1'b0;
		for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++)
			perm_s[n] = rc4_pkg::byte_t'(n);
		key_len = 0;
		idx_i = '0;
		idx_j = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		forever #5 clk = ~clk;
	end

	// sender: keeps valid up until the transfer, then loads the next item or idles
	always @(negedge clk) begin
		if (arst_n && (!item_ch.valid || in_fire)) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				item_ch.valid    <= 1'b1;
				item_ch.op       <= pending_items[0].op;
				item_ch.value    <= pending_items[0].value;
				item_ch.key_last <= pending_items[0].key_last;
				void'(pending_items.pop_front());
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_trigger != hold_served) begin
				hold_served <= hold_trigger;
				hold_left   <= HOLD_LEN;
				res_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left   <= hold_left - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// monitor: predict on input transfers, check output transfers
	always @(posedge clk) begin
		in_fire <= arst_n && item_ch.valid && item_ch.ready;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				rc4_advance(cipher_item_t'{item_ch.op, item_ch.value, item_ch.key_last});
			if (res_ch.valid && res_ch.ready) begin
				if (expected_bytes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("error: result %02h with nothing expected", res_ch.result_byte);
				end else begin
					if (res_ch.result_byte !== expected_bytes[0]) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("error: result_byte expected %02h got %02h",
								expected_bytes[0], res_ch.result_byte);
					end
					void'(expected_bytes.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned r;
		@(posedge arst_n);

		// data before any key runs on the identity permutation; key_last ignored on data
		queue_item(rc4_pkg::OP_DATA, 8'h00, 1'b1);
		queue_item(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
		queue_item(rc4_pkg::OP_DATA, 8'h5A, 1'b1);
		// one-byte keys at both extremes
		queue_item(rc4_pkg::OP_KEY, 8'h00, 1'b1);
		queue_item(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
		queue_item(rc4_pkg::OP_DATA, 8'h00, 1'b1);
		queue_item(rc4_pkg::OP_KEY, 8'hFF, 1'b1);
		queue_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
		// short multi-byte key
		queue_item(rc4_pkg::OP_KEY, 8'hFF, 1'b0);
		queue_item(rc4_pkg::OP_KEY, 8'h80, 1'b0);
		queue_item(rc4_pkg::OP_KEY, 8'h01, 1'b1);
		queue_item(rc4_pkg::OP_DATA, 8'hFF, 1'b1);
		queue_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
		queue_item(rc4_pkg::OP_DATA, 8'hA5, 1'b0);
		// overflowing key: the extra bytes are dropped, the last still starts the schedule
		queue_key(259);
		queue_data(8);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 35;
					recv_idle_pct = 74;
				end
				1: begin
					send_idle_pct = 74;
					recv_idle_pct = 35;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					// long receiver stall while the sender keeps offering data
					hold_trigger++;
					queue_data(30);
				end
			endcase
			while (queued_total < (ph + 1) * ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					queue_key((r == 0) ? $urandom_range(256, 258) : $urandom_range(1, 16));
				else if (r < 19)
					queue_key($urandom_range(1, 3));
				else if (r < 23)
					// stray key bytes with no last flag; data after them stays on the old keystream
					for (int k = $urandom_range(1, 3); k > 0; k--)
						queue_item(rc4_pkg::OP_KEY, rc4_pkg::byte_t'($urandom_range(0, 255)),
							1'b0);
				else
					queue_data($urandom_range(1, 40));
			end
			queue_data(4);
			wait_sent();
			if (ph == 0) begin
				// sender pauses until every outstanding result is back
				while (expected_bytes.size() != 0)
					@(posedge clk);
			end
		end

		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_bytes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/rc4_pkg.sv
src/rc4_in_if.sv
src/rc4_out_if.sv
src/rc4_ram.sv
src/rc4_seq.sv
src/rc4_datapath.sv
src/rc4_stream_cipher_unit.sv
verif/rc4_stream_cipher_unit_test.sv
